/* rtl/core/coap_pkg.sv */
// Shared types and constants for the CoAP message parser.
// Holds result kinds, value formats, option numbers and the classify function.
// No dependencies.
`timescale 1ns / 1ps

package coap_pkg;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 112;

  // result kinds
  localparam logic [3:0] KIND_HEADER    = 4'd0;
  localparam logic [3:0] KIND_TOKEN     = 4'd1;
  localparam logic [3:0] KIND_OPT_START = 4'd2;
  localparam logic [3:0] KIND_OPT_VALUE = 4'd3;
  localparam logic [3:0] KIND_PAYLOAD   = 4'd4;
  localparam logic [3:0] KIND_END       = 4'd5;
  localparam logic [3:0] KIND_CORRUPT   = 4'd6;
  localparam logic [3:0] KIND_TRUNC     = 4'd7;
  localparam logic [3:0] KIND_BAD_VER   = 4'd8;

  // option value formats
  localparam logic [2:0] FMT_NONE   = 3'd0;
  localparam logic [2:0] FMT_OPAQUE = 3'd1;
  localparam logic [2:0] FMT_UINT   = 3'd2;
  localparam logic [2:0] FMT_STRING = 3'd3;
  localparam logic [2:0] FMT_EMPTY  = 3'd4;

  // known option numbers
  localparam logic [15:0] ONUM_IF_MATCH       = 16'd1;
  localparam logic [15:0] ONUM_URI_HOST       = 16'd3;
  localparam logic [15:0] ONUM_ETAG           = 16'd4;
  localparam logic [15:0] ONUM_IF_NONE_MATCH  = 16'd5;
  localparam logic [15:0] ONUM_OBSERVE        = 16'd6;
  localparam logic [15:0] ONUM_URI_PORT       = 16'd7;
  localparam logic [15:0] ONUM_LOCATION_PATH  = 16'd8;
  localparam logic [15:0] ONUM_URI_PATH       = 16'd11;
  localparam logic [15:0] ONUM_CONTENT_FORMAT = 16'd12;
  localparam logic [15:0] ONUM_MAX_AGE        = 16'd14;
  localparam logic [15:0] ONUM_URI_QUERY      = 16'd15;
  localparam logic [15:0] ONUM_ACCEPT         = 16'd17;
  localparam logic [15:0] ONUM_LOCATION_QUERY = 16'd20;
  localparam logic [15:0] ONUM_PROXY_URI      = 16'd35;
  localparam logic [15:0] ONUM_PROXY_SCHEME   = 16'd39;
  localparam logic [15:0] ONUM_SIZE1          = 16'd60;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  byte_value;
    logic [1:0]  msg_type;
    logic [3:0]  token_len;
    logic [2:0]  code_class;
    logic [4:0]  code_detail;
    logic [15:0] msg_id;
    logic [15:0] option_number;
    logic [15:0] length;
    logic [2:0]  value_format;
    logic [31:0] int_value;
    logic        last_result;
  } coap_result_t;

  // results produced by one accepted byte
  typedef struct packed {
    logic [1:0]   cnt;
    coap_result_t r0;
    coap_result_t r1;
  } coap_push_t;

  // format of an option from its number and value length
  function automatic logic [2:0] coap_classify(input logic [15:0] opt, input logic [15:0] len);
    logic [2:0] fmt;
    fmt = FMT_NONE;
    case (opt) inside
      ONUM_ETAG:
        fmt = (len >= 16'd1 && len <= 16'd8) ? FMT_OPAQUE : FMT_NONE;
      ONUM_IF_MATCH:
        fmt = (len <= 16'd8) ? FMT_OPAQUE : FMT_NONE;
      ONUM_OBSERVE:
        fmt = (len <= 16'd3) ? FMT_UINT : FMT_NONE;
      ONUM_PROXY_URI:
        fmt = (len >= 16'd1 && len <= 16'd1034) ? FMT_STRING : FMT_NONE;
      ONUM_URI_HOST, ONUM_PROXY_SCHEME:
        fmt = (len >= 16'd1 && len <= 16'd255) ? FMT_STRING : FMT_NONE;
      ONUM_LOCATION_PATH, ONUM_URI_PATH, ONUM_URI_QUERY, ONUM_LOCATION_QUERY:
        fmt = (len <= 16'd255) ? FMT_STRING : FMT_NONE;
      ONUM_URI_PORT, ONUM_CONTENT_FORMAT, ONUM_ACCEPT:
        fmt = (len <= 16'd2) ? FMT_UINT : FMT_NONE;
      ONUM_MAX_AGE, ONUM_SIZE1:
        fmt = (len <= 16'd4) ? FMT_UINT : FMT_NONE;
      ONUM_IF_NONE_MATCH:
        fmt = (len == 16'd0) ? FMT_EMPTY : FMT_NONE;
      default:
        fmt = FMT_NONE;
    endcase
    return fmt;
  endfunction

endpackage

/* rtl/core/coap_parse.sv */
// Per-byte parse state of the CoAP message parser.
// Updates the parse state for each accepted word and produces up to two results.
// Depends on coap_pkg.
`timescale 1ns / 1ps

module coap_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output coap_pkg::coap_push_t push
);
  import coap_pkg::*;

  // parse phases
  localparam logic [3:0] PH_H0      = 4'd0;
  localparam logic [3:0] PH_H1      = 4'd1;
  localparam logic [3:0] PH_H2      = 4'd2;
  localparam logic [3:0] PH_H3      = 4'd3;
  localparam logic [3:0] PH_TOKEN   = 4'd4;
  localparam logic [3:0] PH_OPT     = 4'd5;
  localparam logic [3:0] PH_D1      = 4'd6;
  localparam logic [3:0] PH_D2H     = 4'd7;
  localparam logic [3:0] PH_D2L     = 4'd8;
  localparam logic [3:0] PH_L1      = 4'd9;
  localparam logic [3:0] PH_L2H     = 4'd10;
  localparam logic [3:0] PH_L2L     = 4'd11;
  localparam logic [3:0] PH_VALUE   = 4'd12;
  localparam logic [3:0] PH_PAYLOAD = 4'd13;
  localparam logic [3:0] PH_SKIP    = 4'd14;

  localparam logic [7:0]  MARKER   = 8'hff;
  localparam logic [3:0]  NIB_RSVD = 4'd15;
  localparam logic [3:0]  NIB_EXT1 = 4'd13;
  localparam logic [3:0]  NIB_EXT2 = 4'd14;
  localparam logic [15:0] EXT1_ADD = 16'd13;
  localparam logic [15:0] EXT2_ADD = 16'd269;
  localparam logic [1:0]  VERSION  = 2'd1;

  logic [3:0]  phase_r, phase_nxt;
  logic [23:0] hdr_r, hdr_nxt;
  logic [15:0] byte_cnt_r, byte_cnt_nxt;
  logic [15:0] opt_sum_r, opt_sum_nxt;
  logic [15:0] delta_r, delta_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] value_left_r, value_left_nxt;
  logic [31:0] int_acc_r, int_acc_nxt;
  logic [2:0]  fmt_r, fmt_nxt;

  logic         do_after_delta;
  logic         do_finish;
  logic         main_vld;
  logic         end_vld;
  coap_result_t res_main;
  coap_result_t res_end;
  logic [15:0]  sum_new;
  logic [2:0]   fmt_new;

  // state update and result forming for one word
  always_comb begin
    phase_nxt      = phase_r;
    hdr_nxt        = hdr_r;
    byte_cnt_nxt   = byte_cnt_r;
    opt_sum_nxt    = opt_sum_r;
    delta_nxt      = delta_r;
    len_nxt        = len_r;
    value_left_nxt = value_left_r;
    int_acc_nxt    = int_acc_r;
    fmt_nxt        = fmt_r;
    do_after_delta = 1'b0;
    do_finish      = 1'b0;
    main_vld       = 1'b0;
    end_vld        = 1'b0;
    res_main       = '0;
    res_end        = '0;
    sum_new        = '0;
    fmt_new        = FMT_NONE;
    push           = '0;

    if (byte_valid) begin
      unique case (phase_r)
        PH_H0: begin
          hdr_nxt   = {data_byte, 16'h0000};
          phase_nxt = PH_H1;
        end
        PH_H1: begin
          hdr_nxt[15:8] = data_byte;
          phase_nxt     = PH_H2;
        end
        PH_H2: begin
          hdr_nxt[7:0] = data_byte;
          phase_nxt    = PH_H3;
        end
        PH_H3: begin
          main_vld             = 1'b1;
          res_main.kind        = (hdr_r[23:22] == VERSION) ? KIND_HEADER : KIND_BAD_VER;
          res_main.msg_type    = hdr_r[21:20];
          res_main.token_len   = hdr_r[19:16];
          res_main.code_class  = hdr_r[15:13];
          res_main.code_detail = hdr_r[12:8];
          res_main.msg_id      = {hdr_r[7:0], data_byte};
          if (hdr_r[23:22] != VERSION) begin
            phase_nxt = PH_SKIP;
          end else begin
            byte_cnt_nxt = {12'h000, hdr_r[19:16]};
            opt_sum_nxt  = '0;
            phase_nxt    = (hdr_r[19:16] != 4'd0) ? PH_TOKEN : PH_OPT;
          end
        end
        PH_TOKEN: begin
          main_vld            = 1'b1;
          res_main.kind       = KIND_TOKEN;
          res_main.byte_value = data_byte;
          byte_cnt_nxt        = byte_cnt_r - 16'd1;
          if (byte_cnt_nxt == 16'd0) begin
            phase_nxt = PH_OPT;
          end
        end
        PH_OPT: begin
          if (data_byte == MARKER) begin
            byte_cnt_nxt = 16'd1;
            phase_nxt    = PH_PAYLOAD;
          end else begin
            delta_nxt = {12'h000, data_byte[7:4]};
            len_nxt   = {12'h000, data_byte[3:0]};
            if (data_byte[7:4] == NIB_RSVD || data_byte[3:0] == NIB_RSVD) begin
              main_vld      = 1'b1;
              res_main.kind = KIND_CORRUPT;
              phase_nxt     = PH_SKIP;
            end else if (data_byte[7:4] == NIB_EXT1) begin
              phase_nxt = PH_D1;
            end else if (data_byte[7:4] == NIB_EXT2) begin
              phase_nxt = PH_D2H;
            end else begin
              do_after_delta = 1'b1;
            end
          end
        end
        PH_D1: begin
          delta_nxt      = {8'h00, data_byte} + EXT1_ADD;
          do_after_delta = 1'b1;
        end
        PH_D2H: begin
          delta_nxt = {data_byte, 8'h00};
          phase_nxt = PH_D2L;
        end
        PH_D2L: begin
          delta_nxt      = {delta_r[15:8], data_byte} + EXT2_ADD;
          do_after_delta = 1'b1;
        end
        PH_L1: begin
          len_nxt   = {8'h00, data_byte} + EXT1_ADD;
          do_finish = 1'b1;
        end
        PH_L2H: begin
          len_nxt   = {data_byte, 8'h00};
          phase_nxt = PH_L2L;
        end
        PH_L2L: begin
          len_nxt   = {len_r[15:8], data_byte} + EXT2_ADD;
          do_finish = 1'b1;
        end
        PH_VALUE: begin
          if (fmt_r != FMT_NONE) begin
            int_acc_nxt            = {int_acc_r[23:0], data_byte};
            main_vld               = 1'b1;
            res_main.kind          = KIND_OPT_VALUE;
            res_main.byte_value    = data_byte;
            res_main.option_number = opt_sum_r;
            res_main.length        = len_r;
            res_main.value_format  = fmt_r;
            res_main.int_value     = (fmt_r == FMT_UINT) ? int_acc_nxt : 32'h0;
          end
          value_left_nxt = value_left_r - 16'd1;
          if (value_left_nxt == 16'd0) begin
            phase_nxt = PH_OPT;
          end
        end
        PH_PAYLOAD: begin
          if (byte_cnt_r != 16'hffff) begin
            byte_cnt_nxt = byte_cnt_r + 16'd1;
          end
        end
        default: begin
        end
      endcase

      // extended length forms wait for more bytes
      if (do_after_delta) begin
        if (len_nxt == {12'h000, NIB_EXT1}) begin
          phase_nxt = PH_L1;
        end else if (len_nxt == {12'h000, NIB_EXT2}) begin
          phase_nxt = PH_L2H;
        end else begin
          do_finish = 1'b1;
        end
      end

      // option header complete: accumulate number and classify
      if (do_finish) begin
        sum_new                = opt_sum_r + delta_nxt;
        fmt_new                = coap_classify(sum_new, len_nxt);
        opt_sum_nxt            = sum_new;
        fmt_nxt                = fmt_new;
        value_left_nxt         = len_nxt;
        int_acc_nxt            = '0;
        main_vld               = 1'b1;
        res_main.kind          = KIND_OPT_START;
        res_main.option_number = sum_new;
        res_main.length        = len_nxt;
        res_main.value_format  = fmt_new;
        phase_nxt              = (len_nxt != 16'd0) ? PH_VALUE : PH_OPT;
      end

      // end of message: report how it ended, unless the message is skipped, and return to reset state
      if (last_byte) begin
        if (phase_nxt == PH_H1 || phase_nxt == PH_H2 || phase_nxt == PH_H3) begin
          end_vld      = 1'b1;
          res_end.kind = KIND_CORRUPT;
        end else if (phase_nxt == PH_TOKEN ||
                     (phase_nxt >= PH_D1 && phase_nxt <= PH_L2L) ||
                     (phase_nxt == PH_VALUE && fmt_nxt != FMT_NONE)) begin
          end_vld      = 1'b1;
          res_end.kind = KIND_TRUNC;
        end else if (phase_nxt == PH_OPT || phase_nxt == PH_VALUE) begin
          end_vld      = 1'b1;
          res_end.kind = KIND_END;
        end else if (phase_nxt == PH_PAYLOAD) begin
          end_vld        = 1'b1;
          res_end.kind   = KIND_PAYLOAD;
          res_end.length = byte_cnt_nxt;
        end
        phase_nxt      = PH_H0;
        hdr_nxt        = '0;
        byte_cnt_nxt   = '0;
        opt_sum_nxt    = '0;
        delta_nxt      = '0;
        len_nxt        = '0;
        value_left_nxt = '0;
        int_acc_nxt    = '0;
        fmt_nxt        = FMT_NONE;
      end

      // order results, mark the final one
      if (main_vld && end_vld) begin
        res_end.last_result = 1'b1;
        push.cnt = 2'd2;
        push.r0  = res_main;
        push.r1  = res_end;
      end else if (main_vld) begin
        res_main.last_result = 1'b1;
        push.cnt = 2'd1;
        push.r0  = res_main;
      end else if (end_vld) begin
        res_end.last_result = 1'b1;
        push.cnt = 2'd1;
        push.r0  = res_end;
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_H0;
      hdr_r        <= '0;
      byte_cnt_r   <= '0;
      opt_sum_r    <= '0;
      delta_r      <= '0;
      len_r        <= '0;
      value_left_r <= '0;
      int_acc_r    <= '0;
      fmt_r        <= FMT_NONE;
    end else begin
      phase_r      <= phase_nxt;
      hdr_r        <= hdr_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      opt_sum_r    <= opt_sum_nxt;
      delta_r      <= delta_nxt;
      len_r        <= len_nxt;
      value_left_r <= value_left_nxt;
      int_acc_r    <= int_acc_nxt;
      fmt_r        <= fmt_nxt;
    end
  end

`ifndef SYNTH
  // a message end always brings the parser back to the first header byte
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    byte_valid && last_byte |=> phase_r == PH_H0)
    else $error("phase not back to header after last byte");

  // a discarded message stays silent until its last byte
  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    byte_valid && !last_byte && phase_r == PH_SKIP |-> push.cnt == 2'd0)
    else $error("result produced while skipping message");

  // value phase is only entered with bytes left to take
  a_value_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_VALUE |-> value_left_r != 16'd0)
    else $error("value phase with no bytes left");
`endif

endmodule

/* rtl/core/coap_message_parser.sv */
// Results are written into a result buffer and offered on the output from there, behind any still queued.
// Throughput: one byte per cycle; a byte causes at most two results, queued in a small
// result buffer drained one per cycle while out_tready is high, so input stalls only when it lacks room for two.
// Reset: synchronous active-low rst_n returns the parser to the first header byte
// and empties the result buffer.
// Top level of the CoAP message parser; instantiates coap_parse. Depends on coap_pkg.
`timescale 1ns / 1ps

module coap_message_parser #(
  parameter int FIFO_DEPTH = 4  // power of two, at least 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [coap_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] data_byte
  input  logic                                in_tlast,   // last_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [coap_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [7:0] byte_value, [9:8] msg_type, [13:10] token_len, [16:14] code_class,
  // [21:17] code_detail, [37:22] msg_id, [53:38] option_number, [69:54] length,
  // [72:70] value_format, [104:73] int_value, [111:105] zero
  output logic [3:0]                          out_tuser,  // kind
  output logic                                out_tlast   // last_result
);
  import coap_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic         in_acc;
  logic         pop;
  coap_push_t   push;
  coap_result_t head;

  coap_result_t fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] wr_ptr_inc;

  // input side: accept while two result slots are free
  assign in_tready = (count_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_acc    = in_tvalid & in_tready;

  coap_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_acc),
    .data_byte  (in_tdata[7:0]),
    .last_byte  (in_tlast),
    .push       (push)
  );

  // result buffer pointers
  assign pop        = out_tvalid & out_tready;
  assign wr_ptr_inc = wr_ptr_r + PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign count_nxt  = count_r + CNT_W'(push.cnt) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // result buffer storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      fifo_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      fifo_r[wr_ptr_inc] <= push.r1;
    end
  end

  // output side
  assign head       = fifo_r[rd_ptr_r];
  assign out_tvalid = (count_r != '0);
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last_result;
  assign out_tdata  = {7'h00, head.int_value, head.value_format, head.length,
                       head.option_number, head.msg_id, head.code_detail,
                       head.code_class, head.token_len, head.msg_type,
                       head.byte_value};

`ifndef SYNTH
  // buffer never overfills
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("result buffer overflow");

  // results only arrive for an accepted word
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> in_acc)
    else $error("result produced without an accepted word");

  // message-ending kinds always close the results of their word
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_END || out_tuser == KIND_TRUNC ||
                   out_tuser == KIND_PAYLOAD) |-> out_tlast)
    else $error("message end result not marked last");
`endif

endmodule

/* dv/tb.sv */
// Self-checking testbench for coap_message_parser: directed and random CoAP messages.
// Results are predicted per byte and compared field by field. Depends on coap_pkg.
`timescale 1ns / 1ps

module tb;
  import coap_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  localparam logic [15:0] KNOWN_OPTS [16] = '{
    ONUM_IF_MATCH, ONUM_URI_HOST, ONUM_ETAG, ONUM_IF_NONE_MATCH, ONUM_OBSERVE,
    ONUM_URI_PORT, ONUM_LOCATION_PATH, ONUM_URI_PATH, ONUM_CONTENT_FORMAT, ONUM_MAX_AGE,
    ONUM_URI_QUERY, ONUM_ACCEPT, ONUM_LOCATION_QUERY, ONUM_PROXY_URI, ONUM_PROXY_SCHEME,
    ONUM_SIZE1
  };

  // where the parser stands within a message
  typedef enum logic [3:0] {
    P_HDR0, P_HDR1, P_HDR2, P_HDR3, P_TOKEN, P_OPT, P_DLT1, P_DLT2H, P_DLT2L,
    P_LEN1, P_LEN2H, P_LEN2L, P_VALUE, P_PAYLOAD, P_SKIP
  } parse_phase_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  byte_value;
    logic [1:0]  msg_type;
    logic [3:0]  token_len;
    logic [2:0]  code_class;
    logic [4:0]  code_detail;
    logic [15:0] msg_id;
    logic [15:0] option_number;
    logic [15:0] length;
    logic [2:0]  value_format;
    logic [31:0] int_value;
    logic        last_result;
  } parse_rec_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [7:0] data_byte
  logic                   in_tlast = 1'b0; // last_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [7:0] byte_value, [9:8] msg_type, [13:10] token_len, [16:14] code_class,
  // [21:17] code_detail, [37:22] msg_id, [53:38] option_number, [69:54] length,
  // [72:70] value_format, [104:73] int_value, [111:105] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [3:0]             out_tuser;       // kind
  logic                   out_tlast;       // last_result

  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  parse_rec_t  pending_results[$];
  parse_rec_t  step_recs[$];
  logic [7:0]  frame[$];

  // parser state mirror
  parse_phase_t pp_phase;
  logic [23:0]  hdr_bytes;
  logic [15:0]  byte_cnt;
  logic [15:0]  opt_num;
  logic [15:0]  delta_acc;
  logic [15:0]  len_acc;
  logic [15:0]  val_left;
  logic [31:0]  uint_acc;
  logic [2:0]   fmt_held;

  coap_message_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // result prediction

  function automatic void clear_parse_state();
    pp_phase  = P_HDR0;
    hdr_bytes = '0;
    byte_cnt  = '0;
    opt_num   = '0;
    delta_acc = '0;
    len_acc   = '0;
    val_left  = '0;
    uint_acc  = '0;
    fmt_held  = FMT_NONE;
  endfunction

  function automatic parse_rec_t blank_rec(logic [3:0] k);
    parse_rec_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  // value format from option number and value length
  function automatic logic [2:0] option_format(logic [15:0] num, logic [15:0] len);
    logic nonzero;
    logic upto255;
    nonzero = (len != 16'd0);
    upto255 = (len <= 16'd255);
    case (num)
      ONUM_IF_MATCH:       return (len <= 16'd8) ? FMT_OPAQUE : FMT_NONE;
      ONUM_ETAG:           return (nonzero && len <= 16'd8) ? FMT_OPAQUE : FMT_NONE;
      ONUM_OBSERVE:        return (len <= 16'd3) ? FMT_UINT : FMT_NONE;
      ONUM_PROXY_URI:      return (nonzero && len <= 16'd1034) ? FMT_STRING : FMT_NONE;
      ONUM_URI_HOST,
      ONUM_PROXY_SCHEME:   return (nonzero && upto255) ? FMT_STRING : FMT_NONE;
      ONUM_LOCATION_PATH,
      ONUM_URI_PATH,
      ONUM_URI_QUERY,
      ONUM_LOCATION_QUERY: return upto255 ? FMT_STRING : FMT_NONE;
      ONUM_URI_PORT,
      ONUM_CONTENT_FORMAT,
      ONUM_ACCEPT:         return (len <= 16'd2) ? FMT_UINT : FMT_NONE;
      ONUM_MAX_AGE,
      ONUM_SIZE1:          return (len <= 16'd4) ? FMT_UINT : FMT_NONE;
      ONUM_IF_NONE_MATCH:  return nonzero ? FMT_NONE : FMT_EMPTY;
      default:             return FMT_NONE;
    endcase
  endfunction

  // option header complete: report it and move to its value
  function automatic void close_option();
    parse_rec_t r;
    opt_num  = opt_num + delta_acc;
    fmt_held = option_format(opt_num, len_acc);
    val_left = len_acc;
    uint_acc = '0;
    r = blank_rec(KIND_OPT_START);
    r.option_number = opt_num;
    r.length        = len_acc;
    r.value_format  = fmt_held;
    step_recs.push_back(r);
    pp_phase = (val_left != 16'd0) ? P_VALUE : P_OPT;
  endfunction

  function automatic void delta_done();
    if (len_acc == 16'd13) pp_phase = P_LEN1;
    else if (len_acc == 16'd14) pp_phase = P_LEN2H;
    else close_option();
  endfunction

  // expected results of one accepted word
  function automatic void predict_parse(logic [7:0] b, logic lst);
    parse_rec_t r;
    step_recs.delete();
    case (pp_phase)
      P_HDR0: begin
        hdr_bytes = {b, 16'h0000};
        pp_phase  = P_HDR1;
      end
      P_HDR1: begin
        hdr_bytes[15:8] = b;
        pp_phase = P_HDR2;
      end
      P_HDR2: begin
        hdr_bytes[7:0] = b;
        pp_phase = P_HDR3;
      end
      P_HDR3: begin
        r = blank_rec((hdr_bytes[23:22] == 2'd1) ? KIND_HEADER : KIND_BAD_VER);
        r.msg_type    = hdr_bytes[21:20];
        r.token_len   = hdr_bytes[19:16];
        r.code_class  = hdr_bytes[15:13];
        r.code_detail = hdr_bytes[12:8];
        r.msg_id      = {hdr_bytes[7:0], b};
        step_recs.push_back(r);
        if (hdr_bytes[23:22] != 2'd1) begin
          pp_phase = P_SKIP;
        end else begin
          byte_cnt = {12'h000, hdr_bytes[19:16]};
          opt_num  = '0;
          pp_phase = (byte_cnt != 16'd0) ? P_TOKEN : P_OPT;
        end
      end
      P_TOKEN: begin
        r = blank_rec(KIND_TOKEN);
        r.byte_value = b;
        step_recs.push_back(r);
        byte_cnt = byte_cnt - 16'd1;
        if (byte_cnt == 16'd0) pp_phase = P_OPT;
      end
      P_OPT: begin
        if (b == 8'hff) begin
          byte_cnt = 16'd1;
          pp_phase = P_PAYLOAD;
        end else begin
          delta_acc = {12'h000, b[7:4]};
          len_acc   = {12'h000, b[3:0]};
          if (b[7:4] == 4'hf || b[3:0] == 4'hf) begin
            step_recs.push_back(blank_rec(KIND_CORRUPT));
            pp_phase = P_SKIP;
          end else if (b[7:4] == 4'd13) begin
            pp_phase = P_DLT1;
          end else if (b[7:4] == 4'd14) begin
            pp_phase = P_DLT2H;
          end else begin
            delta_done();
          end
        end
      end
      P_DLT1: begin
        delta_acc = {8'h00, b} + 16'd13;
        delta_done();
      end
      P_DLT2H: begin
        delta_acc = {b, 8'h00};
        pp_phase  = P_DLT2L;
      end
      P_DLT2L: begin
        delta_acc = {delta_acc[15:8], b} + 16'd269;
        delta_done();
      end
      P_LEN1: begin
        len_acc = {8'h00, b} + 16'd13;
        close_option();
      end
      P_LEN2H: begin
        len_acc  = {b, 8'h00};
        pp_phase = P_LEN2L;
      end
      P_LEN2L: begin
        len_acc = {len_acc[15:8], b} + 16'd269;
        close_option();
      end
      P_VALUE: begin
        // unrecognized values are skipped without a result
        if (fmt_held != FMT_NONE) begin
          uint_acc = {uint_acc[23:0], b};
          r = blank_rec(KIND_OPT_VALUE);
          r.byte_value    = b;
          r.option_number = opt_num;
          r.length        = len_acc;
          r.value_format  = fmt_held;
          r.int_value     = (fmt_held == FMT_UINT) ? uint_acc : 32'd0;
          step_recs.push_back(r);
        end
        val_left = val_left - 16'd1;
        if (val_left == 16'd0) pp_phase = P_OPT;
      end
      P_PAYLOAD: begin
        if (byte_cnt != 16'hffff) byte_cnt = byte_cnt + 16'd1;
      end
      default: ;
    endcase

    // end of message
    if (lst) begin
      if (pp_phase inside {P_HDR1, P_HDR2, P_HDR3}) begin
        step_recs.push_back(blank_rec(KIND_CORRUPT));
      end else if (pp_phase inside {P_TOKEN, P_DLT1, P_DLT2H, P_DLT2L, P_LEN1, P_LEN2H,
                                    P_LEN2L} || (pp_phase == P_VALUE && fmt_held != FMT_NONE)) begin
        step_recs.push_back(blank_rec(KIND_TRUNC));
      end else if (pp_phase == P_OPT || pp_phase == P_VALUE) begin
        step_recs.push_back(blank_rec(KIND_END));
      end else if (pp_phase == P_PAYLOAD) begin
        r = blank_rec(KIND_PAYLOAD);
        r.length = byte_cnt;
        step_recs.push_back(r);
      end
      clear_parse_state();
    end

    if (step_recs.size() != 0) step_recs[step_recs.size() - 1].last_result = 1'b1;
    foreach (step_recs[i]) pending_results.push_back(step_recs[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // result checking

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    parse_rec_t got;
    parse_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind          = out_tuser;
      got.byte_value    = out_tdata[7:0];
      got.msg_type      = out_tdata[9:8];
      got.token_len     = out_tdata[13:10];
      got.code_class    = out_tdata[16:14];
      got.code_detail   = out_tdata[21:17];
      got.msg_id        = out_tdata[37:22];
      got.option_number = out_tdata[53:38];
      got.length        = out_tdata[69:54];
      got.value_format  = out_tdata[72:70];
      got.int_value     = out_tdata[104:73];
      got.last_result   = out_tlast;
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none actual kind %0d data %h",
                 $time, got.kind, out_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(got.kind));
        check_field("byte_value", 32'(want.byte_value), 32'(got.byte_value));
        check_field("msg_type", 32'(want.msg_type), 32'(got.msg_type));
        check_field("token_len", 32'(want.token_len), 32'(got.token_len));
        check_field("code_class", 32'(want.code_class), 32'(got.code_class));
        check_field("code_detail", 32'(want.code_detail), 32'(got.code_detail));
        check_field("msg_id", 32'(want.msg_id), 32'(got.msg_id));
        check_field("option_number", 32'(want.option_number), 32'(got.option_number));
        check_field("length", 32'(want.length), 32'(got.length));
        check_field("value_format", 32'(want.value_format), 32'(got.value_format));
        check_field("int_value", want.int_value, got.int_value);
        check_field("last_result", 32'(want.last_result), 32'(got.last_result));
        check_field("pad", 32'd0, {25'd0, out_tdata[111:105]});
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers

  task automatic send_byte(input logic [7:0] b, input logic lst);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_parse(b, lst);
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // sender holds off until every result has come back
  task automatic wait_drained();
    go_idle();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic put_rand(input int unsigned n);
    repeat (n) frame.push_back(8'($urandom));
  endtask

  function automatic logic [3:0] ext_nibble(int unsigned v);
    return (v < 13) ? 4'(v) : (v < 269) ? 4'd13 : 4'd14;
  endfunction

  task automatic push_ext(input int unsigned v);
    int unsigned x;
    if (v >= 269) begin
      x = v - 269;
      frame.push_back(8'(x >> 8));
      frame.push_back(8'(x));
    end else if (v >= 13) begin
      frame.push_back(8'(v - 13));
    end
  endtask

  task automatic push_option(input int unsigned delta, input int unsigned len);
    frame.push_back({ext_nibble(delta), ext_nibble(len)});
    push_ext(delta);
    push_ext(len);
    put_rand(len);
  endtask

  // longest well-formed value used for random frames
  function automatic int unsigned len_limit(logic [15:0] opt);
    case (opt)
      ONUM_IF_MATCH, ONUM_ETAG:                      return 8;
      ONUM_OBSERVE:                                  return 3;
      ONUM_URI_PORT, ONUM_CONTENT_FORMAT, ONUM_ACCEPT: return 2;
      ONUM_MAX_AGE, ONUM_SIZE1:                      return 4;
      ONUM_IF_NONE_MATCH:                            return 0;
      default:                                       return 20;
    endcase
  endfunction

  // mostly well-formed messages, with noise, corruption and cut-off ends
  task automatic build_random_frame();
    int unsigned tkl;
    int unsigned cur;
    int unsigned target;
    int unsigned delta;
    int unsigned len;
    int unsigned lim;
    int unsigned roll;
    logic [1:0]  ver;
    frame.delete();
    if ($urandom_range(99) < 8) begin
      put_rand($urandom_range(20, 1));
      return;
    end
    ver = ($urandom_range(99) < 92) ? 2'd1 : 2'($urandom_range(3));
    tkl = ($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(15, 9);
    frame.push_back({ver, 2'($urandom), 4'(tkl)});
    put_rand(3 + tkl);
    cur = 0;
    repeat ($urandom_range(5)) begin
      if ($urandom_range(99) < 70) begin
        target = 32'(KNOWN_OPTS[4'($urandom_range(15))]);
        if (target < cur) target = cur + $urandom_range(2);
        delta = target - cur;
        lim   = len_limit(16'(target));
        roll  = $urandom_range(99);
        if (roll < 10) len = lim + 1 + $urandom_range(2);
        else if (roll < 16) len = $urandom_range(30, 13);
        else len = $urandom_range(lim);
      end else begin
        roll = $urandom_range(99);
        if (roll < 60) delta = $urandom_range(12);
        else if (roll < 90) delta = $urandom_range(268, 13);
        else delta = $urandom_range(269 + 65535, 269);
        len = $urandom_range(6);
      end
      push_option(delta, len);
      cur = (cur + delta) & 32'hffff;
    end
    roll = $urandom_range(99);
    if (roll < 5) begin
      if ($urandom_range(1)) frame.push_back({4'hf, 4'($urandom_range(14))});
      else frame.push_back({4'($urandom_range(14)), 4'hf});
      put_rand($urandom_range(3));
    end else if (roll < 45) begin
      frame.push_back(8'hff);
      put_rand($urandom_range(10));
    end
    if ($urandom_range(99) < 12 && frame.size() > 1)
      frame = frame[0:$urandom_range(frame.size() - 2)];
  endtask

  // ---------------------------------------------------------------------------
  // tests

  // header decode, short headers, bad versions, longest token
  task automatic test_header_fields();
    frame = '{8'h40, 8'h01, 8'h12, 8'h34};
    send_frame();
    frame = '{8'h40};
    send_frame();
    frame = '{8'h40, 8'h01};
    send_frame();
    frame = '{8'h40, 8'h01, 8'h00};
    send_frame();
    frame = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h12};
    send_frame();
    frame = '{8'hbf, 8'h45, 8'h00, 8'h01, 8'h11, 8'h22};
    send_frame();
    frame = '{8'hff, 8'hff, 8'hff, 8'hff};
    send_frame();
    frame = '{8'h7f, 8'hff, 8'hff, 8'hff};
    for (int i = 0; i < 15; i++) frame.push_back((i % 2) ? 8'hff : 8'h00);
    send_frame();
  endtask

  // every known option, each in or out of its length range
  task automatic test_known_options();
    frame = '{8'h44, 8'h01, 8'hab, 8'hcd, 8'hde, 8'had, 8'hbe, 8'hef,
              8'h10, 8'h21, 8'h61, 8'h11, 8'hff, 8'h10, 8'h13, 8'h01, 8'h02, 8'h03,
              8'h12, 8'h16, 8'h33, 8'h11, 8'h41, 8'h30, 8'h11, 8'h2a,
              8'h24, 8'hff, 8'hff, 8'hff, 8'hff, 8'h11, 8'h3d, 8'h22, 8'h01, 8'h00,
              8'h31, 8'h78, 8'hd1, 8'h02, 8'h68, 8'h40, 8'hd1, 8'h08, 8'h61,
              8'hff, 8'h55, 8'h66};
    send_frame();
    // unrecognized lengths are skipped silently
    frame = '{8'h40, 8'h01, 8'h00, 8'h00, 8'h19};
    put_rand(9);
    frame.push_back(8'h30);
    frame.push_back(8'h10);
    frame.push_back(8'h11);
    frame.push_back(8'h00);
    frame.push_back(8'h14);
    put_rand(4);
    send_frame();
  endtask

  // one- and two-byte extended delta and length, option number wrap
  task automatic test_extended_forms();
    frame = '{8'h40, 8'h01, 8'h00, 8'h02, 8'he0, 8'hfe, 8'hf2, 8'h41, 8'h62, 8'h0d, 8'h00};
    put_rand(13);
    frame.push_back(8'hd0);
    frame.push_back(8'h01);
    frame.push_back(8'hdd);
    frame.push_back(8'h05);
    frame.push_back(8'h07);
    put_rand(20);
    send_frame();
    // two-byte length that wraps, value cut short
    frame = '{8'h40, 8'h01, 8'h00, 8'h03, 8'h0e, 8'hff, 8'hff, 8'h01, 8'h02, 8'h03};
    send_frame();
  endtask

  // reserved nibbles, truncation, marker alone
  task automatic test_error_cases();
    frame = '{8'h40, 8'h01, 8'h00, 8'h04, 8'hf0, 8'h11, 8'h22};
    send_frame();
    frame = '{8'h40, 8'h01, 8'h00, 8'h05, 8'h1f};
    send_frame();
    frame = '{8'h42, 8'h01, 8'h00, 8'h06, 8'haa};
    send_frame();
    frame = '{8'h40, 8'h01, 8'h00, 8'h07, 8'he0, 8'h01};
    send_frame();
    frame = '{8'h40, 8'h01, 8'h00, 8'h08, 8'h0d};
    send_frame();
    frame = '{8'h40, 8'h01, 8'h00, 8'h09, 8'hb3, 8'h61, 8'h62};
    send_frame();
    frame = '{8'h40, 8'h01, 8'h00, 8'h0a, 8'h03, 8'h01};
    send_frame();
    frame = '{8'h40, 8'h01, 8'h00, 8'h0b, 8'hff};
    send_frame();
  endtask

  // proxy uri at and one past its longest length, both cut short, and a payload
  task automatic test_long_values();
    frame = '{8'h40, 8'h01, 8'h00, 8'h0c, 8'hde, 8'h16, 8'h02, 8'hfd};
    put_rand(3);
    send_frame();
    frame = '{8'h40, 8'h01, 8'h00, 8'h0c, 8'hde, 8'h16, 8'h02, 8'hfe};
    put_rand(2);
    send_frame();
    frame = '{8'h40, 8'h01, 8'h00, 8'h0d, 8'hff};
    put_rand(30);
    send_frame();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned n_words);
    int unsigned sent;
    sent = 0;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    while (sent < n_words) begin
      build_random_frame();
      send_frame();
      sent += frame.size();
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence

  initial begin
    clear_parse_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_header_fields();
    test_known_options();
    test_extended_forms();
    test_error_cases();
    wait_drained();
    test_long_values();
    wait_drained();
    test_random_traffic(0, 0, 194);
    test_random_traffic(73, 0, 194);
    test_random_traffic(0, 73, 194);
    test_random_traffic(25, 25, 194);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/coap_pkg.sv
rtl/core/coap_parse.sv
rtl/core/coap_message_parser.sv
dv/tb.sv
